### src/ttdb_pkg.sv
// Shared constants and controller/datapath interface types for the
// turntable direction-to-buttons block. No dependencies.
package ttdb_pkg;

  // Direction hold length in ticks
  localparam int HOLD_TICKS = 100;

  // Field widths
  localparam int BTN_W   = 11;
  localparam int WORD_W  = 15;
  localparam int COUNT_W = 16;
  localparam int BYTE_W  = 8;
  localparam int PAD_W   = 16;

  // Divider: two quotient bits per cycle over the count
  localparam int DIV_STEPS = COUNT_W / 2;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  // Direction codes
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  // Pad mapping modes
  localparam logic [1:0] PAD_OFF     = 2'd0;
  localparam logic [1:0] PAD_A       = 2'd1;
  localparam logic [1:0] PAD_B_AXIS1 = 2'd2;
  localparam logic [1:0] PAD_B_AXIS2 = 2'd3;

  // Register indexes
  localparam logic [1:0] REG_SENS_ONE = 2'd0;
  localparam logic [1:0] REG_SENS_TWO = 2'd1;
  localparam logic [1:0] REG_PAD_MODE = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;   // take the request, update axis state, load divider with axis one
    logic load_two;  // save axis one quotient, load divider with axis two
    logic step;      // advance the divider by two bits
    logic load_out;  // fill the output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;  // output register empty or being taken this cycle
  } status_t;

endpackage

### src/ttdb_ctrl.sv
// Sequencer for the turntable direction-to-buttons block.
// Depends on ttdb_pkg for command and status types.
module ttdb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  ttdb_pkg::status_t status_i,
  output ttdb_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV1  = 3'd1;
  localparam logic [2:0] ST_LOAD2 = 3'd2;
  localparam logic [2:0] ST_DIV2  = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  localparam logic [ttdb_pkg::CNT_W-1:0] LAST_STEP =
    ttdb_pkg::CNT_W'(ttdb_pkg::DIV_STEPS - 1);

  logic [2:0] state_q, state_d;
  logic [ttdb_pkg::CNT_W-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          cnt_d         = '0;
          state_d       = ST_DIV1;
        end
      end
      ST_DIV1: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          state_d = ST_LOAD2;
        end
      end
      ST_LOAD2: begin
        cmd_o.load_two = 1'b1;
        cnt_d          = '0;
        state_d        = ST_DIV2;
      end
      ST_DIV2: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### src/ttdb_dp.sv
// Datapath: axis direction tracking, pad mapping, shared divider, scaling
// and output register. Depends on ttdb_pkg.
module ttdb_dp #(
  parameter int HOLD_TICKS = ttdb_pkg::HOLD_TICKS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  ttdb_pkg::cmd_t                  cmd_i,
  output ttdb_pkg::status_t               status_o,
  input  logic [ttdb_pkg::BTN_W-1:0]      raw_buttons_i,
  input  logic [ttdb_pkg::COUNT_W-1:0]    count_one_i,
  input  logic [ttdb_pkg::COUNT_W-1:0]    count_two_i,
  input  logic signed [ttdb_pkg::BYTE_W-1:0] sens_one_i,
  input  logic signed [ttdb_pkg::BYTE_W-1:0] sens_two_i,
  input  logic [1:0]                      pad_mode_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ttdb_pkg::WORD_W-1:0]     button_word_o,
  output logic [ttdb_pkg::BYTE_W-1:0]     axis_one_out_o,
  output logic [ttdb_pkg::BYTE_W-1:0]     axis_two_out_o,
  output logic [ttdb_pkg::PAD_W-1:0]      pad_word_o
);

  localparam logic signed [7:0] HOLD_POS = 8'(HOLD_TICKS);
  localparam logic signed [7:0] HOLD_NEG = 8'(-HOLD_TICKS);

  typedef struct packed {
    logic [7:0]        last;
    logic [1:0]        dir;
    logic signed [7:0] hold;
  } axis_t;

  // One tick of direction tracking for an axis
  function automatic axis_t axis_next(logic [15:0] count, axis_t cur);
    axis_t             nxt;
    logic signed [7:0] d;
    nxt = cur;
    d   = signed'(count[7:0] - cur.last);
    if ((cur.dir == ttdb_pkg::DIR_UP && d > 8'sd0) || d > 8'sd1) begin
      nxt.hold = HOLD_POS;
    end else if ((cur.dir == ttdb_pkg::DIR_DOWN && d < 8'sd0) || d < -8'sd1) begin
      nxt.hold = HOLD_NEG;
    end else if (cur.hold > 8'sd0) begin
      nxt.hold = cur.hold - 8'sd1;
    end else if (cur.hold < 8'sd0) begin
      nxt.hold = cur.hold + 8'sd1;
    end else begin
      nxt.dir = ttdb_pkg::DIR_NONE;
    end
    nxt.last = count[7:0];
    if (d > 8'sd0) begin
      nxt.dir = ttdb_pkg::DIR_UP;
    end else if (d < 8'sd0) begin
      nxt.dir = ttdb_pkg::DIR_DOWN;
    end
    return nxt;
  endfunction

  // Console pad bit mapping, before inversion
  function automatic logic [15:0] pad_map(logic [14:0] b, logic [1:0] mode);
    logic [15:0] ps;
    ps = '0;
    if (mode == ttdb_pkg::PAD_A) begin
      ps[5]  = 1'b1;
      ps[6]  = 1'b1;
      ps[7]  = 1'b1;
      ps[12] = b[0];
      ps[13] = b[1];
      ps[11] = b[2];
      ps[14] = b[3];
      ps[10] = b[4];
      ps[15] = b[5];
      ps[9]  = b[6];
      ps[4]  = b[7];
      ps[8]  = b[8];
      ps[0]  = b[10];
      ps[3]  = b[9];
    end else begin
      ps[15] = b[0];
      ps[10] = b[1];
      ps[14] = b[2];
      ps[11] = b[3];
      ps[13] = b[4];
      ps[8]  = b[5];
      ps[7]  = b[6];
      ps[0]  = b[10];
      ps[3]  = b[9];
      if (mode == ttdb_pkg::PAD_B_AXIS1) begin
        ps[4] = b[11];
        ps[6] = b[12];
      end else begin
        ps[4] = b[13];
        ps[6] = b[14];
      end
    end
    return ps;
  endfunction

  // Scale a count: divide (quotient given), multiply or pass the low byte
  function automatic logic [7:0] scale(logic [15:0] count, logic signed [7:0] sens,
                                       logic [7:0] quot);
    logic [7:0] prod;
    prod = count[7:0] * sens[7:0];
    if (sens < 8'sd0) begin
      return quot;
    end else if (sens > 8'sd0) begin
      return prod;
    end
    return count[7:0];
  endfunction

  axis_t axis_one_q, axis_two_q, axis_one_d, axis_two_d;
  logic [ttdb_pkg::PAD_W-1:0]   pad_store_q;
  logic [ttdb_pkg::WORD_W-1:0]  btn_q, btn_d;
  logic [ttdb_pkg::COUNT_W-1:0] cnt_one_q, cnt_two_q;
  logic [7:0]                   quot_one_q;

  // Divider registers
  logic [ttdb_pkg::COUNT_W-1:0] dvd_q, dvd_d;
  logic [7:0]                   rem_q, rem_d, div_q;
  logic [8:0]                   r9a, r9b;
  logic [7:0]                   rem_mid;
  logic                         gea, geb;

  logic                         out_valid_q;
  logic [ttdb_pkg::WORD_W-1:0]  button_word_q;
  logic [7:0]                   axis_one_q8, axis_two_q8;
  logic [ttdb_pkg::PAD_W-1:0]   pad_word_q;

  // Axis tracking and button word for the incoming request
  always_comb begin
    axis_one_d = axis_next(count_one_i, axis_one_q);
    axis_two_d = axis_next(count_two_i, axis_two_q);
    btn_d      = {axis_two_d.hold < 8'sd0, axis_two_d.hold > 8'sd0,
                  axis_one_d.hold < 8'sd0, axis_one_d.hold > 8'sd0,
                  ~raw_buttons_i};
  end

  // Two restoring division steps per cycle
  always_comb begin
    r9a     = {rem_q, dvd_q[15]};
    gea     = (r9a >= {1'b0, div_q});
    rem_mid = gea ? 8'(r9a - {1'b0, div_q}) : r9a[7:0];
    r9b     = {rem_mid, dvd_q[14]};
    geb     = (r9b >= {1'b0, div_q});
    rem_d   = geb ? 8'(r9b - {1'b0, div_q}) : r9b[7:0];
    dvd_d   = {dvd_q[13:0], gea, geb};
  end

  // Capture request and update tracking state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_one_q  <= '0;
      axis_two_q  <= '0;
      pad_store_q <= '0;
    end else if (cmd_i.capture) begin
      axis_one_q <= axis_one_d;
      axis_two_q <= axis_two_d;
      if (pad_mode_i != ttdb_pkg::PAD_OFF) begin
        pad_store_q <= ~pad_map(btn_d, pad_mode_i);
      end
    end
  end

  // Working payload and divider
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      btn_q     <= btn_d;
      cnt_one_q <= count_one_i;
      cnt_two_q <= count_two_i;
      dvd_q     <= count_one_i;
      rem_q     <= '0;
      div_q     <= 8'(-sens_one_i);
    end else if (cmd_i.load_two) begin
      quot_one_q <= dvd_q[7:0];
      dvd_q      <= cnt_two_q;
      rem_q      <= '0;
      div_q      <= 8'(-sens_two_i);
    end else if (cmd_i.step) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      button_word_q <= btn_q;
      axis_one_q8   <= scale(cnt_one_q, sens_one_i, quot_one_q);
      axis_two_q8   <= scale(cnt_two_q, sens_two_i, dvd_q[7:0]);
      pad_word_q    <= pad_store_q;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign button_word_o     = button_word_q;
  assign axis_one_out_o    = axis_one_q8;
  assign axis_two_out_o    = axis_two_q8;
  assign pad_word_o        = pad_word_q;

endmodule

### src/turntable_direction_to_buttons.sv
// Top level of the turntable direction-to-buttons block: configuration
// registers on an APB-style port, controller and datapath.
// Depends on ttdb_pkg, ttdb_ctrl and ttdb_dp.
//
// Usage: once per tick present the eleven active-low button levels and the
// two quadrature counts on the input channel (in_valid_i/in_ready_o). Each
// request yields one result on the output channel (out_valid_o/out_ready_i):
// pressed buttons with four direction bits, both scaled counts, and the
// inverted pad word.
// Each request runs through the shared divider, which produces two quotient
// bits per cycle for each axis in turn: after acceptance it divides axis one,
// loads the second axis, divides axis two, and then fills the output register
// once it is free. A new request is accepted only after the previous result
// has entered the output register.
// A finished result sits in the output register; the next request is
// accepted meanwhile, and its result waits in the datapath until the
// register frees up, so a stalled receiver only delays the block.
// Reset clears the direction state, holds, pad store, registers and the
// output valid. Write configuration only while the block is idle.
module turntable_direction_to_buttons #(
  parameter int HOLD_TICKS = ttdb_pkg::HOLD_TICKS
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [ttdb_pkg::BTN_W-1:0]      raw_buttons_i,
  input  logic [ttdb_pkg::COUNT_W-1:0]    count_one_i,
  input  logic [ttdb_pkg::COUNT_W-1:0]    count_two_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [ttdb_pkg::WORD_W-1:0]     button_word_o,
  output logic [ttdb_pkg::BYTE_W-1:0]     axis_one_out_o,
  output logic [ttdb_pkg::BYTE_W-1:0]     axis_two_out_o,
  output logic [ttdb_pkg::PAD_W-1:0]      pad_word_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [3:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  logic signed [7:0] sens_one_q, sens_two_q;
  logic [1:0]        pad_mode_q;
  logic              wr_en;
  logic [1:0]        reg_idx;
  ttdb_pkg::cmd_t    cmd;
  ttdb_pkg::status_t status;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sens_one_q <= '0;
      sens_two_q <= '0;
      pad_mode_q <= ttdb_pkg::PAD_OFF;
    end else if (wr_en) begin
      unique case (reg_idx)
        ttdb_pkg::REG_SENS_ONE: sens_one_q <= pwdata[7:0];
        ttdb_pkg::REG_SENS_TWO: sens_two_q <= pwdata[7:0];
        ttdb_pkg::REG_PAD_MODE: pad_mode_q <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (reg_idx)
      ttdb_pkg::REG_SENS_ONE: prdata = {24'd0, sens_one_q};
      ttdb_pkg::REG_SENS_TWO: prdata = {24'd0, sens_two_q};
      ttdb_pkg::REG_PAD_MODE: prdata = {30'd0, pad_mode_q};
      default:                prdata = '0;
    endcase
  end

  ttdb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  ttdb_dp #(
    .HOLD_TICKS (HOLD_TICKS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .raw_buttons_i  (raw_buttons_i),
    .count_one_i    (count_one_i),
    .count_two_i    (count_two_i),
    .sens_one_i     (sens_one_q),
    .sens_two_i     (sens_two_q),
    .pad_mode_i     (pad_mode_q),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .button_word_o  (button_word_o),
    .axis_one_out_o (axis_one_out_o),
    .axis_two_out_o (axis_two_out_o),
    .pad_word_o     (pad_word_o)
  );

endmodule

### verif/tb.sv
// Self-checking testbench for turntable_direction_to_buttons: random and directed ticks
// are checked against a cycle-free model of the direction holds, scaling and pad mapping.
// Depends on ttdb_pkg and the turntable_direction_to_buttons RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 25;
  localparam int LONG_HOLD     = 80;
  localparam int STALL_LIMIT   = 2000;

  typedef struct packed {
    logic [ttdb_pkg::BTN_W-1:0]   raw_buttons;
    logic [ttdb_pkg::COUNT_W-1:0] count_one;
    logic [ttdb_pkg::COUNT_W-1:0] count_two;
  } tick_t;

  typedef struct packed {
    logic [ttdb_pkg::WORD_W-1:0] button_word;
    logic [ttdb_pkg::BYTE_W-1:0] axis_one;
    logic [ttdb_pkg::BYTE_W-1:0] axis_two;
    logic [ttdb_pkg::PAD_W-1:0]  pad_word;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Request channel
  logic                         in_valid = 1'b0;
  logic                         in_ready_o;
  logic [ttdb_pkg::BTN_W-1:0]   raw_buttons = '1;
  logic [ttdb_pkg::COUNT_W-1:0] count_one = '0;
  logic [ttdb_pkg::COUNT_W-1:0] count_two = '0;

  // Result channel
  logic                         out_valid_o;
  logic                         out_ready = 1'b0;
  logic [ttdb_pkg::WORD_W-1:0]  button_word_o;
  logic [ttdb_pkg::BYTE_W-1:0]  axis_one_out_o;
  logic [ttdb_pkg::BYTE_W-1:0]  axis_two_out_o;
  logic [ttdb_pkg::PAD_W-1:0]   pad_word_o;

  // Configuration port
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  turntable_direction_to_buttons i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .raw_buttons_i  (raw_buttons),
    .count_one_i    (count_one),
    .count_two_i    (count_two),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .button_word_o  (button_word_o),
    .axis_one_out_o (axis_one_out_o),
    .axis_two_out_o (axis_two_out_o),
    .pad_word_o     (pad_word_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Model state and configuration
  logic [7:0]  last_low_q[2] = '{8'd0, 8'd0};
  logic [1:0]  dir_q[2] = '{ttdb_pkg::DIR_NONE, ttdb_pkg::DIR_NONE};
  int          hold_q[2] = '{0, 0};
  logic [15:0] pad_store_q = '0;
  logic [7:0]  sens_one_q = '0;
  logic [7:0]  sens_two_q = '0;
  logic [1:0]  pad_mode_q = ttdb_pkg::PAD_OFF;

  tick_t   pending_ticks[$];
  report_t expected_reports[$];
  tick_t   cur_tick;
  int      ticks_issued = 0;
  int      reports_seen = 0;
  int      errors = 0;
  int      gap_left = 0;
  int      stall_left = 0;
  int      idle_cycles = 0;
  bit      steady = 1'b0;
  bit      long_hold_req = 1'b0;

  // Stimulus generator state per axis
  logic [15:0] pos_q[2] = '{16'd0, 16'd0};
  int          run_left[2] = '{0, 0};
  int          step_q[2] = '{0, 0};

  function automatic int pick_gap();
    return steady ? 0 : int'($urandom_range(0, 5));
  endfunction

  // Update one axis: signed byte change, hold refresh or decay, direction
  function automatic void advance_axis(int ax, logic [15:0] cnt);
    logic signed [7:0] d;
    d = cnt[7:0] - last_low_q[ax];
    if ((dir_q[ax] == ttdb_pkg::DIR_UP && d > 0) || d > 1) begin
      hold_q[ax] = ttdb_pkg::HOLD_TICKS;
    end else if ((dir_q[ax] == ttdb_pkg::DIR_DOWN && d < 0) || d < -1) begin
      hold_q[ax] = -ttdb_pkg::HOLD_TICKS;
    end else if (hold_q[ax] > 0) begin
      hold_q[ax]--;
    end else if (hold_q[ax] < 0) begin
      hold_q[ax]++;
    end else begin
      dir_q[ax] = ttdb_pkg::DIR_NONE;
    end
    last_low_q[ax] = cnt[7:0];
    if (d > 0) dir_q[ax] = ttdb_pkg::DIR_UP;
    else if (d < 0) dir_q[ax] = ttdb_pkg::DIR_DOWN;
  endfunction

  // Negative sensitivity divides the full count, positive multiplies the low byte
  function automatic logic [7:0] scale_count(logic [15:0] cnt, logic [7:0] sens);
    int s;
    int v;
    s = int'($signed(sens));
    v = int'(cnt);
    if (s < 0) v = v / (-s);
    else if (s > 0) v = (v & 255) * s;
    return v[7:0];
  endfunction

  // Compute the report for one tick and advance the model state
  function automatic report_t predict_report(tick_t t);
    report_t r;
    logic [14:0] w;
    logic [15:0] m;
    advance_axis(0, t.count_one);
    advance_axis(1, t.count_two);
    w = {4'b0000, ~t.raw_buttons};
    if (hold_q[0] > 0) w[11] = 1'b1;
    else if (hold_q[0] < 0) w[12] = 1'b1;
    if (hold_q[1] > 0) w[13] = 1'b1;
    else if (hold_q[1] < 0) w[14] = 1'b1;
    m = '0;
    case (pad_mode_q) inside
      ttdb_pkg::PAD_A: begin
        m[7:5] = 3'b111;
        m[12] = w[0];
        m[13] = w[1];
        m[11] = w[2];
        m[14] = w[3];
        m[10] = w[4];
        m[15] = w[5];
        m[9]  = w[6];
        m[4]  = w[7];
        m[8]  = w[8];
        m[3]  = w[9];
        m[0]  = w[10];
        pad_store_q = ~m;
      end
      ttdb_pkg::PAD_B_AXIS1, ttdb_pkg::PAD_B_AXIS2: begin
        m[15] = w[0];
        m[10] = w[1];
        m[14] = w[2];
        m[11] = w[3];
        m[13] = w[4];
        m[8]  = w[5];
        m[7]  = w[6];
        m[3]  = w[9];
        m[0]  = w[10];
        if (pad_mode_q == ttdb_pkg::PAD_B_AXIS1) begin
          m[4] = w[11];
          m[6] = w[12];
        end else begin
          m[4] = w[13];
          m[6] = w[14];
        end
        pad_store_q = ~m;
      end
      default: ;
    endcase
    r.button_word = w;
    r.axis_one    = scale_count(t.count_one, sens_one_q);
    r.axis_two    = scale_count(t.count_two, sens_two_q);
    r.pad_word    = pad_store_q;
    return r;
  endfunction

  task automatic check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, fname, want, got);
      errors++;
    end
  endtask

  // Driver: present queued requests, hold each until accepted, idle for a random gap, possibly none, between them
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready_o) expected_reports.push_back(predict_report(cur_tick));
      if (!in_valid || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          cur_tick = pending_ticks.pop_front();
          raw_buttons <= cur_tick.raw_buttons;
          count_one   <= cur_tick.count_one;
          count_two   <= cur_tick.count_two;
          in_valid    <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation, then stall at random
  always @(posedge clk_i or negedge rst_ni) begin
    report_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && out_ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h %h %h %h", $time,
                   button_word_o, axis_one_out_o, axis_two_out_o, pad_word_o);
          errors++;
        end else begin
          want = expected_reports.pop_front();
          check_field("button_word", 32'(want.button_word), 32'(button_word_o));
          check_field("axis_one_out", 32'(want.axis_one), 32'(axis_one_out_o));
          check_field("axis_two_out", 32'(want.axis_two), 32'(axis_two_out_o));
          check_field("pad_word", 32'(want.pad_word), 32'(pad_word_o));
        end
        reports_seen++;
        stall_left = pick_gap();
        if (long_hold_req) begin
          stall_left = LONG_HOLD;
          long_hold_req = 1'b0;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) || (psel && penable))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Write one register through the configuration port and mirror it in the model
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      ttdb_pkg::REG_SENS_ONE: sens_one_q = val[7:0];
      ttdb_pkg::REG_SENS_TWO: sens_two_q = val[7:0];
      ttdb_pkg::REG_PAD_MODE: pad_mode_q = val[1:0];
      default: ;
    endcase
  endtask

  task automatic push_tick(logic [10:0] btn, logic [15:0] c1, logic [15:0] c2);
    tick_t t;
    t.raw_buttons = btn;
    t.count_one   = c1;
    t.count_two   = c2;
    pending_ticks.push_back(t);
    ticks_issued++;
  endtask

  function automatic logic [10:0] pick_buttons();
    return ($urandom_range(0, 3) == 0) ? 11'h7ff : 11'($urandom_range(0, 2047));
  endfunction

  // Motion in runs: still, slow, fast, or a jump to a random position
  task automatic gen_motion(int n);
    int r;
    int sgn;
    for (int i = 0; i < n; i++) begin
      for (int ax = 0; ax < 2; ax++) begin
        if (run_left[ax] == 0) begin
          r = $urandom_range(0, 9);
          sgn = $urandom_range(0, 1) ? 1 : -1;
          run_left[ax] = $urandom_range(1, 25);
          if (r < 3) begin
            step_q[ax] = 0;
          end else if (r < 6) begin
            step_q[ax] = sgn;
          end else if (r < 9) begin
            step_q[ax] = sgn * int'($urandom_range(2, 6));
          end else begin
            step_q[ax] = 0;
            pos_q[ax] = 16'($urandom_range(0, 65535));
            run_left[ax] = 1;
          end
        end
        pos_q[ax] = pos_q[ax] + 16'(step_q[ax]);
        run_left[ax]--;
      end
      push_tick(pick_buttons(), pos_q[0], pos_q[1]);
    end
  endtask

  // Wait until every request has been answered, then let the block settle
  task automatic drain();
    while (reports_seen != ticks_issued) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extreme counts, byte wraps, same and opposite slow steps, each button
    write_reg(ttdb_pkg::REG_SENS_ONE, 32'h80);
    write_reg(ttdb_pkg::REG_SENS_TWO, 32'h7f);
    write_reg(ttdb_pkg::REG_PAD_MODE, {30'b0, ttdb_pkg::PAD_A});
    push_tick(11'h000, 16'h0000, 16'h0000);
    push_tick(11'h7ff, 16'hffff, 16'hffff);
    push_tick(11'h555, 16'hfffe, 16'h0000);
    push_tick(11'h2aa, 16'hfffd, 16'h0001);
    push_tick(11'h7fe, 16'h0003, 16'h0001);
    push_tick(11'h3ff, 16'h0083, 16'h0081);
    push_tick(11'h400, 16'h0102, 16'h00ff);
    push_tick(11'h001, 16'h8000, 16'h7fff);
    push_tick(11'h002, 16'h8000, 16'h7fff);
    push_tick(11'h004, 16'h8001, 16'h7ffe);
    for (int k = 0; k < ttdb_pkg::BTN_W; k++) begin
      push_tick(11'h7ff ^ (11'd1 << k), 16'h8001, 16'h7ffe);
    end
    pos_q[0] = 16'h8001;
    pos_q[1] = 16'h7ffe;
    drain();

    // Mapping B on axis one, no idling on either side
    write_reg(ttdb_pkg::REG_SENS_ONE, 32'h7f);
    write_reg(ttdb_pkg::REG_SENS_TWO, 32'h80);
    write_reg(ttdb_pkg::REG_PAD_MODE, {30'b0, ttdb_pkg::PAD_B_AXIS1});
    steady = 1'b1;
    gen_motion(70);
    drain();
    steady = 1'b0;

    // Mapping B on axis two, a long receiver stall, and a long rest to let holds expire
    write_reg(ttdb_pkg::REG_SENS_ONE, 32'hff);
    write_reg(ttdb_pkg::REG_SENS_TWO, 32'h01);
    write_reg(ttdb_pkg::REG_PAD_MODE, {30'b0, ttdb_pkg::PAD_B_AXIS2});
    long_hold_req = 1'b1;
    gen_motion(60);
    for (int i = 0; i < 110; i++) push_tick(pick_buttons(), pos_q[0], pos_q[1]);
    gen_motion(20);
    drain();

    // Pad word frozen, counts passed through
    write_reg(ttdb_pkg::REG_SENS_ONE, 32'h00);
    write_reg(ttdb_pkg::REG_SENS_TWO, 32'h00);
    write_reg(ttdb_pkg::REG_PAD_MODE, {30'b0, ttdb_pkg::PAD_OFF});
    gen_motion(50);
    drain();

    // Random setting
    write_reg(ttdb_pkg::REG_SENS_ONE, $urandom_range(0, 255));
    write_reg(ttdb_pkg::REG_SENS_TWO, $urandom_range(0, 255));
    write_reg(ttdb_pkg::REG_PAD_MODE, $urandom_range(0, 3));
    gen_motion(90);
    drain();

    if (errors == 0 && expected_reports.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
